// ----- rtl/assert_macros.svh -----
// Assertion helpers used by ftig_back.
// ASSERT_PROP expects signals named clock and reset, ASSERT_PROP_RST only clock, in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising clock edge, switched off while reset is high
`define ASSERT_PROP(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included
`define ASSERT_PROP_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`else

`define ASSERT_PROP(label, prop, msg)
`define ASSERT_PROP_RST(label, prop, msg)

`endif

`endif

// ----- rtl/ftig_pkg.sv -----
package ftig_pkg;

   // Fixed datapath widths
   localparam int PHASE_BITS  = 32;
   localparam int TABLE_BITS  = 10;
   localparam int SAMPLE_BITS = 16;
   localparam int STEP_BITS   = 32;
   localparam int DEV_BITS    = 32;
   localparam int GAIN_BITS   = 40;
   localparam int TICK_BITS   = 24;
   localparam int OP_BITS     = 2;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 40;

   // Quarter-wave table: entries 0 .. QSTEPS inclusive
   localparam int QSTEPS     = 1 << (TABLE_BITS - 2);
   localparam int QADDR_BITS = TABLE_BITS - 1;

   localparam logic [63:0] AMPL       = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
   localparam logic [63:0] PIHALF_Q30 = 64'd1686629713;

   localparam logic [PHASE_BITS-1:0] QUARTER_TURN = {2'b01, {(PHASE_BITS - 2){1'b0}}};

   // Operation codes
   localparam logic [OP_BITS-1:0] OP_SAMPLE  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_REPLAY  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_ADVANCE = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AUDIO_STEP     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEVIATION_STEP = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RATIO_GAIN     = 2'd2;

   typedef struct packed {
      logic [OP_BITS-1:0]   op;
      logic [TICK_BITS-1:0] tick_samples;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } push_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   typedef struct packed {
      logic [STEP_BITS-1:0] audio_step;
      logic [DEV_BITS-1:0]  deviation_step;
      logic [GAIN_BITS-1:0] ratio_gain;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      audio_step:     32'd12884902,
      deviation_step: 32'd322122547,
      ratio_gain:     40'd34177927000
   };

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SMP_MUL,
      BK_SMP_OUT,
      BK_REPLAY,
      BK_ADV_MUL1,
      BK_ADV_DIFF,
      BK_ADV_MUL2,
      BK_ADV_ADD
   } back_state_type;

   typedef logic [SAMPLE_BITS-2:0] qtab_type [0:QSTEPS];

   // Quarter sine in Q30 by an eleven-term Taylor series, scaled to the amplitude
   function automatic qtab_type build_qtab();
      qtab_type          tab;
      logic [63:0]       x;
      logic [63:0]       x2;
      logic [63:0]       term;
      logic [63:0]       v;
      logic signed [63:0] sum;
      for (int k = 0; k <= QSTEPS; k++) begin
         x    = (PIHALF_Q30 * 64'(k)) >> (TABLE_BITS - 2);
         x2   = (x * x) >> 30;
         term = x;
         sum  = $signed(x);
         for (int n = 1; n <= 10; n++) begin
            term = (term * x2) >> 30;
            unique case (n)
               1:       term = term / 64'd6;
               2:       term = term / 64'd20;
               3:       term = term / 64'd42;
               4:       term = term / 64'd72;
               5:       term = term / 64'd110;
               6:       term = term / 64'd156;
               7:       term = term / 64'd210;
               8:       term = term / 64'd272;
               9:       term = term / 64'd342;
               default: term = term / 64'd420;
            endcase
            if (n[0]) begin
               sum = sum - $signed(term);
            end else begin
               sum = sum + $signed(term);
            end
         end
         if (sum < 0) begin
            sum = 64'sd0;
         end
         v = (($unsigned(sum) * AMPL) + (64'd1 << 29)) >> 30;
         if (v > AMPL) begin
            v = AMPL;
         end
         tab[k] = v[SAMPLE_BITS-2:0];
      end
      return tab;
   endfunction

   localparam qtab_type QTAB = build_qtab();

   // Full-turn sine from the quarter table, truncated index
   function automatic logic signed [SAMPLE_BITS-1:0] sine_of(input logic [PHASE_BITS-1:0] phase);
      logic [TABLE_BITS-1:0]  idx;
      logic [1:0]             quad;
      logic [TABLE_BITS-3:0]  off;
      logic [QADDR_BITS-1:0]  addr;
      logic [SAMPLE_BITS-1:0] v;
      idx  = phase[PHASE_BITS-1 -: TABLE_BITS];
      quad = idx[TABLE_BITS-1 -: 2];
      off  = idx[TABLE_BITS-3:0];
      addr = quad[0] ? (QADDR_BITS'(QSTEPS) - {1'b0, off}) : {1'b0, off};
      v    = {1'b0, QTAB[addr]};
      return quad[1] ? $signed(-v) : $signed(v);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] cosine_of(input logic [PHASE_BITS-1:0] phase);
      return sine_of(phase + QUARTER_TURN);
   endfunction

endpackage

// ----- rtl/ftig_if.sv -----
// Request channel: operation words
interface ftig_req_if import ftig_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OP_BITS-1:0]   op;
   logic [TICK_BITS-1:0] tick_samples;

   modport source (output valid, output op, output tick_samples, input ready);
   modport sink   (input valid, input op, input tick_samples, output ready);
endinterface

// Response channel: I/Q words
interface ftig_rsp_if import ftig_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] i_out;
   logic signed [SAMPLE_BITS-1:0] q_out;

   modport source (output valid, output i_out, output q_out, input ready);
   modport sink   (input valid, input i_out, input q_out, output ready);
endinterface

// Register write channel
interface ftig_csr_if import ftig_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/ftig_front.sv -----
module ftig_front import ftig_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   ftig_req_if.sink      req_if,
   ftig_csr_if.sink      csr_if,
   input  logic          queue_not_full,
   output push_type      push,
   output cfg_type       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    op_known;

   // Classify: unused op codes are dropped here
   assign op_known = (req_if.op == OP_SAMPLE) || (req_if.op == OP_REPLAY) ||
                     (req_if.op == OP_ADVANCE);

   assign req_if.ready    = queue_not_full;
   assign push.valid      = req_if.valid && queue_not_full && op_known;
   assign push.item.op           = req_if.op;
   assign push.item.tick_samples = req_if.tick_samples;

   // Register file, always ready
   assign csr_if.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_AUDIO_STEP:     cfg_in.audio_step     = csr_if.data[STEP_BITS-1:0];
            CSR_DEVIATION_STEP: cfg_in.deviation_step = csr_if.data[DEV_BITS-1:0];
            CSR_RATIO_GAIN:     cfg_in.ratio_gain     = csr_if.data[GAIN_BITS-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/ftig_queue.sv -----
module ftig_queue import ftig_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic           clock,
   input  logic           reset,
   input  push_type       push,
   input  logic           pop,
   output queue_head_type head,
   output logic           not_full
);

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   item_type              slot_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff;
   logic [PTR_BITS-1:0]   wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff;
   logic [PTR_BITS-1:0]   rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic                  do_push;
   logic                  do_pop;

   assign not_full  = (count_ff != COUNT_BITS'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

   assign do_push = push.valid && not_full;
   assign do_pop  = pop && head.valid;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

// ----- rtl/ftig_back.sv -----
`include "assert_macros.svh"

module ftig_back import ftig_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  queue_head_type head,
   output logic           pop,
   ftig_rsp_if.source     rsp_if
);

   back_state_type state_ff;
   back_state_type state_in;

   // Committed, snapshot and working phases
   logic [PHASE_BITS-1:0] audio_phase_ff,   audio_phase_in;
   logic [PHASE_BITS-1:0] carrier_phase_ff, carrier_phase_in;
   logic [PHASE_BITS-1:0] snap_audio_ff,    snap_audio_in;
   logic [PHASE_BITS-1:0] snap_carrier_ff,  snap_carrier_in;
   logic [PHASE_BITS-1:0] work_audio_ff,    work_audio_in;
   logic [PHASE_BITS-1:0] work_carrier_ff,  work_carrier_in;

   // Working registers
   logic [TICK_BITS-1:0]        tick_ff,  tick_in;
   logic [PHASE_BITS-1:0]       prod_ff,  prod_in;
   logic [PHASE_BITS-1:0]       a1_ff,    a1_in;
   logic signed [SAMPLE_BITS:0] diff_ff,  diff_in;

   // Output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] i_out_ff, i_out_in;
   logic signed [SAMPLE_BITS-1:0] q_out_ff, q_out_in;
   logic                          out_free;

   // Datapath terms
   logic signed [SAMPLE_BITS-1:0]           mod_sine;
   logic signed [PHASE_BITS+SAMPLE_BITS:0]  smp_prod;
   logic [STEP_BITS+TICK_BITS-1:0]          tick_prod;
   logic signed [GAIN_BITS+SAMPLE_BITS+1:0] gain_prod;
   logic [PHASE_BITS-1:0]                   new_carrier;
   logic [PHASE_BITS-1:0]                   a1_sum;
   logic signed [SAMPLE_BITS-1:0]           cos_a0;
   logic signed [SAMPLE_BITS-1:0]           cos_a1;

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // deviation * sin(audio), floor >> (SAMPLE_BITS-1)
   assign mod_sine = sine_of(work_audio_ff);
   assign smp_prod = $signed({1'b0, cfg.deviation_step}) * mod_sine;

   // audio_step * n, wraps
   assign tick_prod = cfg.audio_step * tick_ff;

   // ratio_gain * (cos a0 - cos a1), floor >> SAMPLE_BITS
   assign gain_prod = $signed({1'b0, cfg.ratio_gain}) * diff_ff;

   assign new_carrier = work_carrier_ff + prod_ff;
   assign a1_sum      = audio_phase_ff + prod_ff;
   assign cos_a0      = cosine_of(audio_phase_ff);
   assign cos_a1      = cosine_of(a1_sum);

   // Sequencer: next state and datapath loads
   always_comb begin
      state_in         = state_ff;
      pop              = 1'b0;
      audio_phase_in   = audio_phase_ff;
      carrier_phase_in = carrier_phase_ff;
      snap_audio_in    = snap_audio_ff;
      snap_carrier_in  = snap_carrier_ff;
      work_audio_in    = work_audio_ff;
      work_carrier_in  = work_carrier_ff;
      tick_in          = tick_ff;
      prod_in          = prod_ff;
      a1_in            = a1_ff;
      diff_in          = diff_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_if.ready;
      i_out_in         = i_out_ff;
      q_out_in         = q_out_ff;

      unique case (state_ff)
         BK_IDLE: begin
            if (head.valid) begin
               pop     = 1'b1;
               tick_in = head.item.tick_samples;
               case (head.item.op)
                  OP_SAMPLE:  state_in = BK_SMP_MUL;
                  OP_REPLAY:  state_in = BK_REPLAY;
                  OP_ADVANCE: state_in = BK_ADV_MUL1;
                  default:    state_in = BK_IDLE;
               endcase
            end
         end
         BK_SMP_MUL: begin
            prod_in       = smp_prod[SAMPLE_BITS-1 +: PHASE_BITS];
            work_audio_in = work_audio_ff + cfg.audio_step;
            state_in      = BK_SMP_OUT;
         end
         BK_SMP_OUT: begin
            if (out_free) begin
               work_carrier_in = new_carrier;
               rsp_valid_in    = 1'b1;
               i_out_in        = cosine_of(new_carrier);
               q_out_in        = sine_of(new_carrier);
               state_in        = BK_IDLE;
            end
         end
         BK_REPLAY: begin
            work_audio_in   = snap_audio_ff;
            work_carrier_in = snap_carrier_ff;
            state_in        = BK_IDLE;
         end
         BK_ADV_MUL1: begin
            prod_in  = tick_prod[PHASE_BITS-1:0];
            state_in = BK_ADV_DIFF;
         end
         BK_ADV_DIFF: begin
            a1_in           = a1_sum;
            diff_in         = (SAMPLE_BITS + 1)'(cos_a0) - (SAMPLE_BITS + 1)'(cos_a1);
            snap_audio_in   = audio_phase_ff;
            snap_carrier_in = carrier_phase_ff;
            state_in        = BK_ADV_MUL2;
         end
         BK_ADV_MUL2: begin
            prod_in  = gain_prod[SAMPLE_BITS +: PHASE_BITS];
            state_in = BK_ADV_ADD;
         end
         BK_ADV_ADD: begin
            carrier_phase_in = carrier_phase_ff + prod_ff;
            audio_phase_in   = a1_ff;
            state_in         = BK_IDLE;
         end
      endcase
   end

   // Control state and phases
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= BK_IDLE;
         rsp_valid_ff     <= 1'b0;
         audio_phase_ff   <= '0;
         carrier_phase_ff <= '0;
         snap_audio_ff    <= '0;
         snap_carrier_ff  <= '0;
         work_audio_ff    <= '0;
         work_carrier_ff  <= '0;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         audio_phase_ff   <= audio_phase_in;
         carrier_phase_ff <= carrier_phase_in;
         snap_audio_ff    <= snap_audio_in;
         snap_carrier_ff  <= snap_carrier_in;
         work_audio_ff    <= work_audio_in;
         work_carrier_ff  <= work_carrier_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      tick_ff  <= tick_in;
      prod_ff  <= prod_in;
      a1_ff    <= a1_in;
      diff_ff  <= diff_in;
      i_out_ff <= i_out_in;
      q_out_ff <= q_out_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.i_out = i_out_ff;
   assign rsp_if.q_out = q_out_ff;

   `ASSERT_PROP_RST(a_reset_idle, reset |=> (state_ff == BK_IDLE) && !rsp_valid_ff, "back end not idle after reset")
   `ASSERT_PROP(a_load_from_out, $rose(rsp_valid_ff) |-> $past(state_ff) == BK_SMP_OUT, "output word loaded outside the output step")
   `ASSERT_PROP(a_out_wait, (state_ff == BK_SMP_OUT) && rsp_valid_ff && !rsp_if.ready |=> state_ff == BK_SMP_OUT, "sample step left while output blocked")
   `ASSERT_PROP(a_commit_stable, state_ff != BK_ADV_ADD |=> $stable(audio_phase_ff) && $stable(carrier_phase_ff), "committed phases moved outside the commit step")
   `ASSERT_PROP(a_work_idle, state_ff == BK_IDLE |=> $stable(work_audio_ff) && $stable(work_carrier_ff), "working phases moved while idle")

endmodule

// ----- rtl/fm_tone_iq_generator_top.sv -----
// An accepted sample word passes through the queue, a multiply step, an output step and the
// output register; an output stall holds it in the output step. A replay runs a restore step,
// an advance two multiply steps, a difference step and a commit. QUEUE_DEPTH words buffer the
// front end. Unused op codes are dropped at the front end and never reach the back end.
// Reset is synchronous, active high: phases clear to zero, the queue empties and the
// registers return to their defaults.
module fm_tone_iq_generator_top import ftig_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   ftig_req_if.sink    req_if,
   ftig_rsp_if.source  rsp_if,
   ftig_csr_if.sink    csr_if
);

   push_type       push;
   queue_head_type head;
   logic           queue_not_full;
   logic           pop;
   cfg_type        cfg;

   // Accept, classify and hold the registers
   ftig_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_if),
      .csr_if         (csr_if),
      .queue_not_full (queue_not_full),
      .push           (push),
      .cfg            (cfg)
   );

   // Decoupling queue
   ftig_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (pop),
      .head     (head),
      .not_full (queue_not_full)
   );

   // Phase sequencer and I/Q output
   ftig_back u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .head   (head),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule
